[rtl/core/kvlp_pkg.sv]
package kvlp_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_KEY_START   = 3'd0,
        PH_KEY_DIGITS  = 3'd1,
        PH_SEEK_COMMA  = 3'd2,
        PH_AFTER_COMMA = 3'd3,
        PH_VALUE       = 3'd4,
        PH_DONE        = 3'd5,
        PH_DEAD        = 3'd6
    } phase_t;

    // closing delimiter of the value
    typedef enum logic [1:0] {
        DELIM_NONE   = 2'd0,
        DELIM_SINGLE = 2'd1,
        DELIM_DOUBLE = 2'd2
    } delim_t;

    // input action codes
    typedef enum logic {
        ACT_DATA = 1'b0,
        ACT_EOL  = 1'b1
    } action_t;

    // result kind codes
    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_RECORD = 1'b1
    } kind_t;

    // status codes
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_NO_COMMA = 1'b1;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // key magnitude limit and the largest magnitude that takes one more digit
    localparam logic [31:0] MAG_LIMIT   = 32'h8000_0000;
    localparam logic [31:0] KEY_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ACC_LIM_LOW = 32'd214748364;  // digits 0 to 8
    localparam logic [31:0] ACC_LIM_9   = 32'd214748363;  // digit 9

endpackage

[rtl/core/kvlp_if.sv]
interface kvlp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] data_byte;

    modport source (output valid, action, data_byte, input ready);
    modport sink   (input valid, action, data_byte, output ready);
endinterface

interface kvlp_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic        [7:0]  value_byte;
    logic signed [31:0] key;
    logic               status;

    modport source (output valid, kind, value_byte, key, status, input ready);
    modport sink   (input valid, kind, value_byte, key, status, output ready);
endinterface

[rtl/core/key_value_line_parser_core.sv]
// channel   dir  beat fields
// --------  ---  ---------------------------------------------
// item      in   action (1), data_byte (8)
// result    out  kind (1), value_byte (8), key (32 signed), status (1)
//
// one beat a cycle sustained while the result side is ready; a beat is held in the input register,
// and its result, if it has one, leaves from the result register
// the key multiply-by-ten and saturation compare set the critical path
// rst_n clears the phase, key state and both valid flags at once
// a stalled result holds the result register and, behind it, the input register
module key_value_line_parser_core (
    input  logic              clk,
    input  logic              rst_n,
    kvlp_in_if.sink           item,
    kvlp_out_if.source        result
);

    // input register
    logic       in_vld_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;

    // parser state
    kvlp_pkg::phase_t phase_reg, phase_next;
    kvlp_pkg::delim_t delim_reg, delim_next;
    logic [31:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;

    // result register
    logic               out_vld_reg, out_vld_next;
    logic               out_kind_reg, out_kind_next;
    logic        [7:0]  out_byte_reg, out_byte_next;
    logic signed [31:0] out_key_reg, out_key_next;
    logic               out_status_reg, out_status_next;

    logic        advance;
    logic        proc_fire;
    logic        emit;
    logic [7:0]  c;
    logic        c_blank, c_space, c_digit;
    logic [3:0]  digit;
    logic [31:0] acc_limit;
    logic [31:0] acc_digit;
    logic [31:0] key_final;
    logic        no_comma;

    // the result register frees up when empty or when taken this cycle
    assign advance    = !out_vld_reg || result.ready;
    assign item.ready = !in_vld_reg || advance;
    assign proc_fire  = in_vld_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_vld_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_action_reg <= item.action;
            in_byte_reg   <= item.data_byte;
        end
    end

    // character classes of the held byte
    assign c       = in_byte_reg;
    assign c_blank = (c == kvlp_pkg::CH_SPACE) || (c == kvlp_pkg::CH_TAB);
    assign c_space = (c == kvlp_pkg::CH_SPACE) ||
                     ((c >= kvlp_pkg::CH_TAB) && (c <= kvlp_pkg::CH_CR));
    assign c_digit = (c >= kvlp_pkg::CH_ZERO) && (c <= kvlp_pkg::CH_NINE);
    assign digit   = c[3:0];

    // saturating key accumulate: acc*10 + d, clamp to 2^31 magnitude
    assign acc_limit = (digit == 4'd9) ? kvlp_pkg::ACC_LIM_9 : kvlp_pkg::ACC_LIM_LOW;
    assign acc_digit = (acc_reg > acc_limit) ? kvlp_pkg::MAG_LIMIT
                     : ((acc_reg << 3) + (acc_reg << 1) + {28'd0, digit});

    // signed key from magnitude and sign
    always_comb
    begin
        if (neg_reg)
        begin
            key_final = 32'd0 - acc_reg;
        end
        else if (acc_reg >= kvlp_pkg::MAG_LIMIT)
        begin
            key_final = kvlp_pkg::KEY_POS_MAX;
        end
        else
        begin
            key_final = acc_reg;
        end
    end

    assign no_comma = phase_reg inside {kvlp_pkg::PH_KEY_START, kvlp_pkg::PH_KEY_DIGITS,
                                        kvlp_pkg::PH_SEEK_COMMA, kvlp_pkg::PH_DEAD};

    // phase update and result build for the held beat
    always_comb
    begin
        phase_next      = phase_reg;
        delim_next      = delim_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        emit            = 1'b0;
        out_kind_next   = kvlp_pkg::KIND_BYTE;
        out_byte_next   = c;
        out_key_next    = 32'sd0;
        out_status_next = kvlp_pkg::ST_OK;

        if (proc_fire)
        begin
            if (in_action_reg == kvlp_pkg::ACT_EOL)
            begin
                // finish the record and return to the line start
                emit            = 1'b1;
                out_kind_next   = kvlp_pkg::KIND_RECORD;
                out_byte_next   = 8'd0;
                out_key_next    = $signed(key_final);
                out_status_next = no_comma ? kvlp_pkg::ST_NO_COMMA : kvlp_pkg::ST_OK;
                phase_next      = kvlp_pkg::PH_KEY_START;
                delim_next      = kvlp_pkg::DELIM_NONE;
                acc_next        = 32'd0;
                neg_next        = 1'b0;
            end
            else if (c == kvlp_pkg::CH_NUL)
            begin
                // zero byte ends the text
                if ((phase_reg == kvlp_pkg::PH_AFTER_COMMA) ||
                    (phase_reg == kvlp_pkg::PH_VALUE))
                begin
                    phase_next = kvlp_pkg::PH_DONE;
                end
                else if (phase_reg != kvlp_pkg::PH_DONE)
                begin
                    phase_next = kvlp_pkg::PH_DEAD;
                end
            end
            else
            begin
                unique case (phase_reg) inside
                    kvlp_pkg::PH_KEY_START:
                    begin
                        if (c_space)
                        begin
                            phase_next = kvlp_pkg::PH_KEY_START;
                        end
                        else if ((c == kvlp_pkg::CH_PLUS) || (c == kvlp_pkg::CH_MINUS))
                        begin
                            neg_next   = (c == kvlp_pkg::CH_MINUS);
                            phase_next = kvlp_pkg::PH_KEY_DIGITS;
                        end
                        else if (c_digit)
                        begin
                            acc_next   = acc_digit;
                            phase_next = kvlp_pkg::PH_KEY_DIGITS;
                        end
                        else if (c == kvlp_pkg::CH_COMMA)
                        begin
                            phase_next = kvlp_pkg::PH_AFTER_COMMA;
                        end
                        else
                        begin
                            phase_next = kvlp_pkg::PH_SEEK_COMMA;
                        end
                    end
                    kvlp_pkg::PH_KEY_DIGITS:
                    begin
                        if (c_digit)
                        begin
                            acc_next = acc_digit;
                        end
                        else if (c == kvlp_pkg::CH_COMMA)
                        begin
                            phase_next = kvlp_pkg::PH_AFTER_COMMA;
                        end
                        else
                        begin
                            phase_next = kvlp_pkg::PH_SEEK_COMMA;
                        end
                    end
                    kvlp_pkg::PH_SEEK_COMMA:
                    begin
                        if (c == kvlp_pkg::CH_COMMA)
                        begin
                            phase_next = kvlp_pkg::PH_AFTER_COMMA;
                        end
                    end
                    kvlp_pkg::PH_AFTER_COMMA:
                    begin
                        if (c_blank)
                        begin
                            phase_next = kvlp_pkg::PH_AFTER_COMMA;
                        end
                        else if (c == kvlp_pkg::CH_SQUOTE)
                        begin
                            delim_next = kvlp_pkg::DELIM_SINGLE;
                            phase_next = kvlp_pkg::PH_VALUE;
                        end
                        else if (c == kvlp_pkg::CH_DQUOTE)
                        begin
                            delim_next = kvlp_pkg::DELIM_DOUBLE;
                            phase_next = kvlp_pkg::PH_VALUE;
                        end
                        else if (c == kvlp_pkg::CH_LF)
                        begin
                            phase_next = kvlp_pkg::PH_DONE;
                        end
                        else
                        begin
                            // unquoted value, first byte goes out
                            delim_next = kvlp_pkg::DELIM_NONE;
                            phase_next = kvlp_pkg::PH_VALUE;
                            emit       = 1'b1;
                        end
                    end
                    kvlp_pkg::PH_VALUE:
                    begin
                        if (((delim_reg == kvlp_pkg::DELIM_SINGLE) &&
                             (c == kvlp_pkg::CH_SQUOTE)) ||
                            ((delim_reg == kvlp_pkg::DELIM_DOUBLE) &&
                             (c == kvlp_pkg::CH_DQUOTE)) ||
                            ((delim_reg != kvlp_pkg::DELIM_SINGLE) &&
                             (delim_reg != kvlp_pkg::DELIM_DOUBLE) &&
                             (c == kvlp_pkg::CH_LF)))
                        begin
                            phase_next = kvlp_pkg::PH_DONE;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                    kvlp_pkg::PH_DONE, kvlp_pkg::PH_DEAD:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        // result valid: load on a new beat, drop when taken
        if (proc_fire)
        begin
            out_vld_next = emit;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= kvlp_pkg::PH_KEY_START;
            delim_reg   <= kvlp_pkg::DELIM_NONE;
            acc_reg     <= 32'd0;
            neg_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            delim_reg   <= delim_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // result payload loads only when a result is built
    always_ff @(posedge clk)
    begin
        if (proc_fire && emit)
        begin
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_key_reg    <= out_key_next;
            out_status_reg <= out_status_next;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.kind       = out_kind_reg;
    assign result.value_byte = out_byte_reg;
    assign result.key        = out_key_reg;
    assign result.status     = out_status_reg;

    // end of line always returns the parser to the line start
    a_eol_resets: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && (in_action_reg == kvlp_pkg::ACT_EOL) |=>
        (phase_reg == kvlp_pkg::PH_KEY_START) && (acc_reg == 32'd0) && !neg_reg)
        else $error("parser state not cleared after end of line");

    // key magnitude never passes the saturation point
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg <= kvlp_pkg::MAG_LIMIT)
        else $error("key magnitude above limit");

    // a built result shows up on the output next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && emit |=> result.valid)
        else $error("built result lost");

    // a held input beat never moves while the result register is blocked
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && !result.ready |=> in_vld_reg && $stable(in_byte_reg))
        else $error("input register changed under a stall");

endmodule

[tb/key_value_line_parser_core_test.sv]
module key_value_line_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side
    localparam int SETTLE_CYCLES  = 8;     // wait before the final pending check
    localparam int PHASE_BEATS    = 470;   // random beats per idling phase

    // one result beat as the block should produce it
    typedef struct {
        kvlp_pkg::kind_t    kind;
        logic        [7:0]  value_byte;
        logic signed [31:0] key;
        logic               status;
    } line_result_t;

    // predicts result beats from input beats and checks them in order
    class record_scoreboard;
        kvlp_pkg::phase_t phase;
        logic [31:0]      key_mag;   // magnitude, saturates at 2^31
        logic             key_neg;
        kvlp_pkg::delim_t delim;
        line_result_t expected_q[$];
        int errors;
        int bytes_checked;
        int records_checked;

        function new();
            start_line();
            errors          = 0;
            bytes_checked   = 0;
            records_checked = 0;
        endfunction

        function void start_line();
            phase   = kvlp_pkg::PH_KEY_START;
            key_mag = '0;
            key_neg = 1'b0;
            delim   = kvlp_pkg::DELIM_NONE;
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        function void note_beat(kvlp_pkg::action_t act, logic [7:0] c);
            line_result_t r;
            logic [31:0]  d;
            logic         emit;
            logic         digit;
            logic [7:0]   close_ch;
            emit  = 1'b0;
            digit = (c >= kvlp_pkg::CH_ZERO) && (c <= kvlp_pkg::CH_NINE);
            d     = {24'd0, c - kvlp_pkg::CH_ZERO};
            if (act == kvlp_pkg::ACT_EOL)
            begin
                r.kind       = kvlp_pkg::KIND_RECORD;
                r.value_byte = 8'd0;
                if (key_neg)
                    r.key = 32'd0 - key_mag;
                else if (key_mag >= kvlp_pkg::MAG_LIMIT)
                    r.key = kvlp_pkg::KEY_POS_MAX;
                else
                    r.key = key_mag;
                r.status = (phase == kvlp_pkg::PH_KEY_START ||
                            phase == kvlp_pkg::PH_KEY_DIGITS ||
                            phase == kvlp_pkg::PH_SEEK_COMMA ||
                            phase == kvlp_pkg::PH_DEAD) ?
                           kvlp_pkg::ST_NO_COMMA : kvlp_pkg::ST_OK;
                expected_q.insert(expected_q.size(), r);
                start_line();
                return;
            end
            if (c == kvlp_pkg::CH_NUL)
            begin
                if (phase == kvlp_pkg::PH_AFTER_COMMA || phase == kvlp_pkg::PH_VALUE)
                    phase = kvlp_pkg::PH_DONE;
                else if (phase != kvlp_pkg::PH_DONE)
                    phase = kvlp_pkg::PH_DEAD;
                return;
            end
            case (phase)
                kvlp_pkg::PH_KEY_START:
                    if (c == kvlp_pkg::CH_SPACE ||
                        (c >= kvlp_pkg::CH_TAB && c <= kvlp_pkg::CH_CR))
                    begin
                    end
                    else if (c == kvlp_pkg::CH_PLUS || c == kvlp_pkg::CH_MINUS)
                    begin
                        key_neg = (c == kvlp_pkg::CH_MINUS);
                        phase   = kvlp_pkg::PH_KEY_DIGITS;
                    end
                    else if (digit)
                    begin
                        key_mag = (key_mag > (kvlp_pkg::MAG_LIMIT - d) / 10) ?
                                  kvlp_pkg::MAG_LIMIT : key_mag * 10 + d;
                        phase   = kvlp_pkg::PH_KEY_DIGITS;
                    end
                    else if (c == kvlp_pkg::CH_COMMA)
                        phase = kvlp_pkg::PH_AFTER_COMMA;
                    else
                        phase = kvlp_pkg::PH_SEEK_COMMA;
                kvlp_pkg::PH_KEY_DIGITS:
                    if (digit)
                        key_mag = (key_mag > (kvlp_pkg::MAG_LIMIT - d) / 10) ?
                                  kvlp_pkg::MAG_LIMIT : key_mag * 10 + d;
                    else if (c == kvlp_pkg::CH_COMMA)
                        phase = kvlp_pkg::PH_AFTER_COMMA;
                    else
                        phase = kvlp_pkg::PH_SEEK_COMMA;
                kvlp_pkg::PH_SEEK_COMMA:
                    if (c == kvlp_pkg::CH_COMMA)
                        phase = kvlp_pkg::PH_AFTER_COMMA;
                kvlp_pkg::PH_AFTER_COMMA:
                    if (c == kvlp_pkg::CH_SPACE || c == kvlp_pkg::CH_TAB)
                    begin
                    end
                    else if (c == kvlp_pkg::CH_SQUOTE)
                    begin
                        delim = kvlp_pkg::DELIM_SINGLE;
                        phase = kvlp_pkg::PH_VALUE;
                    end
                    else if (c == kvlp_pkg::CH_DQUOTE)
                    begin
                        delim = kvlp_pkg::DELIM_DOUBLE;
                        phase = kvlp_pkg::PH_VALUE;
                    end
                    else if (c == kvlp_pkg::CH_LF)
                        phase = kvlp_pkg::PH_DONE;
                    else
                    begin
                        delim = kvlp_pkg::DELIM_NONE;
                        phase = kvlp_pkg::PH_VALUE;
                        emit  = 1'b1;
                    end
                kvlp_pkg::PH_VALUE:
                begin
                    close_ch = (delim == kvlp_pkg::DELIM_SINGLE) ? kvlp_pkg::CH_SQUOTE :
                               (delim == kvlp_pkg::DELIM_DOUBLE) ? kvlp_pkg::CH_DQUOTE :
                               kvlp_pkg::CH_LF;
                    if (c == close_ch)
                        phase = kvlp_pkg::PH_DONE;
                    else
                        emit = 1'b1;
                end
                default:
                begin
                end
            endcase
            if (emit)
            begin
                r.kind       = kvlp_pkg::KIND_BYTE;
                r.value_byte = c;
                r.key        = '0;
                r.status     = kvlp_pkg::ST_OK;
                expected_q.insert(expected_q.size(), r);
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic k, logic [7:0] vb, logic [31:0] key, logic st);
            line_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d byte %0h key %0h status %0d",
                         $time, k, vb, key, st);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("kind", 32'(e.kind), 32'(k));
            compare_field("value_byte", 32'(e.value_byte), 32'(vb));
            compare_field("key", e.key, key);
            compare_field("status", 32'(e.status), 32'(st));
            if (e.kind == kvlp_pkg::KIND_RECORD)
                records_checked++;
            else
                bytes_checked++;
        endfunction
    endclass

    logic clk;
    logic rst_n;

    kvlp_in_if  item_ch ();
    kvlp_out_if result_ch ();

    key_value_line_parser_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    record_scoreboard sb;

    // current idling mix, in percent of cycles
    int idle_pct;
    int stall_pct;

    int beats_sent;
    int lines_sent;
    int quiet_cycles;

    // bytes of the line being built, sent as data beats then closed by an end beat
    logic [7:0] line_q[$];

    // free-running clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // result side: check every accepted beat, then pick the next ready at random
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.kind, result_ch.value_byte, result_ch.key,
                            result_ch.status);
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: a long run of cycles with no beat on either side means a hang
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic void append_byte(logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endfunction

    // one input beat: random idle cycles with valid low, then hold until taken
    task automatic send_beat(kvlp_pkg::action_t act, logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.action    <= act;
        item_ch.data_byte <= b;
        do
            @(posedge clk);
        while (!(item_ch.valid && item_ch.ready));
        sb.note_beat(act, b);
        beats_sent++;
    endtask

    // send the built line, then the end-of-line beat with a random don't-care byte
    task automatic send_line();
        foreach (line_q[i])
            send_beat(kvlp_pkg::ACT_DATA, line_q[i]);
        send_beat(kvlp_pkg::ACT_EOL, 8'($urandom_range(0, 255)));
        line_q.delete();
        lines_sent++;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    // mostly printable, now and then any nonzero code
    function automatic logic [7:0] text_byte();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(1, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'($urandom_range(kvlp_pkg::CH_NINE, kvlp_pkg::CH_ZERO));
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(1) ? kvlp_pkg::CH_SPACE : kvlp_pkg::CH_TAB;
    endfunction

    // a random line: mostly well-formed key,value records with random content,
    // the rest raw noise or records broken by missing commas and zero bytes
    task automatic build_random_line();
        int sel;
        logic [7:0] quote;
        line_q.delete();
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(0, 10))
                append_byte(8'($urandom_range(0, 255)));
            return;
        end
        // leading white space, including the wider set the key reader skips
        repeat ($urandom_range(0, 2))
            append_byte(($urandom_range(3) == 0) ? 8'($urandom_range(9, 13))
                                                  : blank_byte());
        sel = $urandom_range(3);
        if (sel == 2)
            append_byte(kvlp_pkg::CH_PLUS);
        else if (sel == 3)
            append_byte(kvlp_pkg::CH_MINUS);
        // key digits: short keys, keys around the 2^31 boundary, and overlong ones
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            add_text("214748364");
            append_byte(digit_byte());
        end
        else if (sel < 22)
            repeat ($urandom_range(10, 12))
                append_byte(digit_byte());
        else
            repeat ($urandom_range(0, 4))
                append_byte(digit_byte());
        // junk between key and comma
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 3))
                append_byte(text_byte());
        if ($urandom_range(99) < 8)
            return;
        append_byte(kvlp_pkg::CH_COMMA);
        repeat ($urandom_range(0, 2))
            append_byte(blank_byte());
        // value: single or double quoted, bare, or an immediate newline
        sel = $urandom_range(9);
        quote = (sel < 3) ? kvlp_pkg::CH_SQUOTE :
                (sel < 6) ? kvlp_pkg::CH_DQUOTE : kvlp_pkg::CH_NUL;
        if (sel == 9)
            append_byte(kvlp_pkg::CH_LF);
        if (quote != kvlp_pkg::CH_NUL)
            append_byte(quote);
        repeat ($urandom_range(0, 6))
            append_byte(text_byte());
        if (quote != kvlp_pkg::CH_NUL && $urandom_range(99) < 80)
            append_byte(quote);
        else if (quote == kvlp_pkg::CH_NUL && $urandom_range(99) < 30)
            append_byte(kvlp_pkg::CH_LF);
        // bytes after the value are ignored
        repeat ($urandom_range(0, 2))
            append_byte(text_byte());
        // a stray zero byte somewhere cuts the text short
        if ($urandom_range(99) < 6)
            line_q.insert($urandom_range(0, line_q.size() - 1), kvlp_pkg::CH_NUL);
    endtask

    // hold the input low until every expected beat has come back
    task automatic wait_results_drained();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_count() != 0);
    endtask

    initial
    begin
        int idle_set[4];
        int stall_set[4];
        int target;
        // free flow, sender idle, receiver stall, then both
        idle_set  = '{0, 71, 0, 16};
        stall_set = '{0, 0, 71, 16};
        sb = new();
        idle_pct     = 0;
        stall_pct    = 0;
        beats_sent   = 0;
        lines_sent   = 0;
        quiet_cycles = 0;
        rst_n               = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.action      = kvlp_pkg::ACT_DATA;
        item_ch.data_byte   = 8'd0;
        result_ch.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed lines
        // negative key past the limit, no comma
        add_text("-9999999999");
        send_line();
        // leading tab, sign without digits, double quote never closed
        add_text("\t+,\"x");
        send_line();
        // zero byte before the comma makes the line one without a comma
        append_byte(kvlp_pkg::CH_NUL);
        add_text(",a");
        send_line();
        // vertical tab before the key, closed single quote, byte 0xff after the value
        append_byte(8'h0B);
        add_text("7,'a'");
        append_byte(8'hFF);
        send_line();
        // junk key and empty value
        add_text("x5, ");
        send_line();
        // bare value ended by a newline, then by a zero byte in another line
        add_text("1,ab\nc");
        send_line();
        add_text("3,v");
        append_byte(kvlp_pkg::CH_NUL);
        add_text("w");
        send_line();
        // empty line
        send_line();
        wait_results_drained();

        // random lines under each idling mix; the input pauses until the
        // result side has drained between mixes
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = idle_set[p];
            stall_pct = stall_set[p];
            target    = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                build_random_line();
                send_line();
            end
            wait_results_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_count() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending_count());
            sb.errors++;
        end

        $display("covered %0d lines in %0d input beats; checked %0d value bytes, %0d records",
                 lines_sent, beats_sent, sb.bytes_checked, sb.records_checked);
        $display("idling mixes: none, sender 71%%, receiver 71%%, both 16%%; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[key_value_line_parser_core.f]
rtl/core/kvlp_pkg.sv
rtl/core/kvlp_if.sv
rtl/core/key_value_line_parser_core.sv
tb/key_value_line_parser_core_test.sv
